[design/btpc_pkg.sv]
package btpc_pkg;

	localparam int DataW = 64;
	localparam int CoefW = 48;
	localparam int AdcW = 20;
	localparam int PaddrW = 5;

	localparam logic [PaddrW-1:0] AddrTemp  = 5'd0;
	localparam logic [PaddrW-1:0] AddrPressA = 5'd8;
	localparam logic [PaddrW-1:0] AddrPressB = 5'd16;
	localparam logic [PaddrW-1:0] AddrPressC = 5'd24;

	localparam logic ActTemp  = 1'b0;
	localparam logic ActPress = 1'b1;

	// Multiply operand pairs chosen by the sequencer.
	typedef enum logic [3:0] {
		M_T_A,    // (adc>>3 - 2*T1) * T2
		M_T_DD,   // d * d
		M_T_B,    // (dd>>12) * T3
		M_T_FIN,  // t_fine * 5
		M_P_AA,   // a * a
		M_P_AAP6, // aa * P6
		M_P_AP5,  // a * P5
		M_P_AAP3, // aa * P3
		M_P_AP2,  // a * P2
		M_P_P1,   // (2^47 + a) * P1
		M_P_N,    // (x) * 3125
		M_P_PS2,  // ps * ps
		M_P_P9,   // P9 * ps2
		M_P_P8    // P8 * p
	} mop_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_T_A, S_T_DD, S_T_B, S_T_FIN, S_T_OUT,
		S_P_AA, S_P_AAP6, S_P_AP5, S_P_AAP3, S_P_AP2, S_P_P1, S_P_CHK,
		S_P_N, S_P_DIV, S_P_WAIT, S_P_PS2, S_P_P9, S_P_P8, S_P_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

endpackage

[design/baro_temp_pressure_compensation_top.sv]
// Barometric temperature / pressure compensation.
// Input stream: s_tdata carries raw_adc[19:0]; s_tuser carries action
// (0 temperature, 1 pressure). One beat in, exactly one beat out.
// Output stream: m_tdata = {divide_by_zero, pressure_q24_8, temperature_centi}
// packed from bit 0 (72 bits with zero fill); m_tuser = result_kind.
// Coefficients are written over the APB port: 0x00 temp, 0x08/0x10/0x18
// pressure sets A/B/C, 48 bits each in a 64-bit data word.
// Every multiply goes through one shared 32x32 multiplier that builds the low
// 64 bits of a product from three partial products. The pressure path also
// uses a 1-bit-per-cycle 64-bit divider, which it skips when the divisor is
// zero. s_tready is high only when idle, so a new beat is not accepted
// until the previous result has been produced.
// The result is held in an output register until m_tready takes it; the
// next input is accepted in the same cycle the result leaves. A stalled
// receiver therefore stalls the input.
// Reset clears coefficients, fine temperature and the control state.
module baro_temp_pressure_compensation_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata, // raw_adc[19:0]
	input  logic                              s_tuser, // action
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [71:0]                       m_tdata, // temperature_centi, pressure_q24_8, divide_by_zero
	output logic                              m_tuser, // result_kind
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [btpc_pkg::PaddrW-1:0]       paddr,
	input  logic [btpc_pkg::DataW-1:0]        pwdata,
	output logic [btpc_pkg::DataW-1:0]        prdata,
	output logic                              pready
);
	logic [47:0] tc_q, pa_q, pb_q, pc_q;
	logic [31:0] tfine_q;
	btpc_pkg::state_t st_q, st_d;
	logic [19:0] adc_q;
	logic [63:0] ra_q, rb_q, rc_q, rd_q;  // scratch
	logic        kind_q, dz_q;
	logic [31:0] temp_out_q, press_out_q;
	logic        mstart, mdone, ddone;
	logic [63:0] ma, mb, mp, dq;
	btpc_pkg::div_ctl_t dctl;
	logic        wr;

	// coefficient fields, sign extended except t1 and p1 (zero extended)
	logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	always_comb begin
		t1 = {48'd0, tc_q[15:0]};
		t2 = {{48{tc_q[31]}}, tc_q[31:16]};
		t3 = {{48{tc_q[47]}}, tc_q[47:32]};
		p1 = {48'd0, pa_q[15:0]};
		p2 = {{48{pa_q[31]}}, pa_q[31:16]};
		p3 = {{48{pa_q[47]}}, pa_q[47:32]};
		p4 = {{48{pb_q[15]}}, pb_q[15:0]};
		p5 = {{48{pb_q[31]}}, pb_q[31:16]};
		p6 = {{48{pb_q[47]}}, pb_q[47:32]};
		p7 = {{48{pc_q[15]}}, pc_q[15:0]};
		p8 = {{48{pc_q[31]}}, pc_q[31:16]};
		p9 = {{48{pc_q[47]}}, pc_q[47:32]};
	end

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	always_comb begin
		unique case (paddr)
			btpc_pkg::AddrTemp:   prdata = {16'd0, tc_q};
			btpc_pkg::AddrPressA: prdata = {16'd0, pa_q};
			btpc_pkg::AddrPressB: prdata = {16'd0, pb_q};
			btpc_pkg::AddrPressC: prdata = {16'd0, pc_q};
			default:              prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= 48'd0; pa_q <= 48'd0; pb_q <= 48'd0; pc_q <= 48'd0;
		end else if (wr) begin
			unique case (paddr)
				btpc_pkg::AddrTemp:   tc_q <= pwdata[47:0];
				btpc_pkg::AddrPressA: pa_q <= pwdata[47:0];
				btpc_pkg::AddrPressB: pb_q <= pwdata[47:0];
				btpc_pkg::AddrPressC: pc_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	// mult operand select by state
	logic [31:0] tx32, td32, tdd;
	always_comb begin
		tx32 = {15'd0, adc_q[19:3]} - {15'd0, tc_q[15:0], 1'b0};
		td32 = {16'd0, adc_q[19:4]} - {16'd0, tc_q[15:0]};
		tdd  = {{12{ra_q[31]}}, ra_q[31:12]};
		ma = 64'd0; mb = 64'd0;
		unique case (st_q)
			btpc_pkg::S_T_A:    begin ma = {32'd0, tx32}; mb = t2; end
			btpc_pkg::S_T_DD:   begin ma = {32'd0, td32}; mb = {32'd0, td32}; end
			btpc_pkg::S_T_B:    begin ma = {32'd0, tdd}; mb = t3; end
			btpc_pkg::S_T_FIN:  begin ma = {32'd0, tfine_q}; mb = 64'd5; end
			btpc_pkg::S_P_AA:   begin ma = ra_q; mb = ra_q; end
			btpc_pkg::S_P_AAP6: begin ma = rb_q; mb = p6; end
			btpc_pkg::S_P_AP5:  begin ma = ra_q; mb = p5; end
			btpc_pkg::S_P_AAP3: begin ma = rb_q; mb = p3; end
			btpc_pkg::S_P_AP2:  begin ma = ra_q; mb = p2; end
			btpc_pkg::S_P_P1:   begin ma = rd_q; mb = p1; end
			btpc_pkg::S_P_N:    begin ma = rd_q; mb = 64'd3125; end
			btpc_pkg::S_P_PS2:  begin ma = {{13{ra_q[63]}}, ra_q[63:13]};
				mb = {{13{ra_q[63]}}, ra_q[63:13]}; end
			btpc_pkg::S_P_P9:   begin ma = rb_q; mb = p9; end
			btpc_pkg::S_P_P8:   begin ma = ra_q; mb = p8; end
			default: ;
		endcase
	end

	btpc_mul u_mul (.clk, .arst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp));
	btpc_div u_div (.clk, .arst_n, .ctl_in(dctl), .dividend(rd_q), .divisor(ra_q),
		.done(ddone), .quotient(dq));

	// each mult state: first cycle launches, wait for done
	logic launched_q;
	logic mul_state;
	always_comb begin
		unique case (st_q)
			btpc_pkg::S_T_A, btpc_pkg::S_T_DD, btpc_pkg::S_T_B, btpc_pkg::S_T_FIN,
			btpc_pkg::S_P_AA, btpc_pkg::S_P_AAP6, btpc_pkg::S_P_AP5,
			btpc_pkg::S_P_AAP3, btpc_pkg::S_P_AP2, btpc_pkg::S_P_P1,
			btpc_pkg::S_P_N, btpc_pkg::S_P_PS2, btpc_pkg::S_P_P9,
			btpc_pkg::S_P_P8: mul_state = 1'b1;
			default:          mul_state = 1'b0;
		endcase
	end
	assign mstart = mul_state & ~launched_q;
	assign dctl.start = (st_q == btpc_pkg::S_P_DIV);

	assign s_tready = (st_q == btpc_pkg::S_IDLE) && (!m_tvalid || m_tready);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			btpc_pkg::S_IDLE:
				if (s_tvalid && s_tready)
					st_d = (s_tuser == btpc_pkg::ActPress) ? btpc_pkg::S_P_AA : btpc_pkg::S_T_A;
			btpc_pkg::S_T_A:    if (mdone) st_d = btpc_pkg::S_T_DD;
			btpc_pkg::S_T_DD:   if (mdone) st_d = btpc_pkg::S_T_B;
			btpc_pkg::S_T_B:    if (mdone) st_d = btpc_pkg::S_T_OUT;
			btpc_pkg::S_T_OUT:  st_d = btpc_pkg::S_T_FIN;
			btpc_pkg::S_T_FIN:  if (mdone) st_d = btpc_pkg::S_OUT;
			btpc_pkg::S_P_AA:   if (mdone) st_d = btpc_pkg::S_P_AAP6;
			btpc_pkg::S_P_AAP6: if (mdone) st_d = btpc_pkg::S_P_AP5;
			btpc_pkg::S_P_AP5:  if (mdone) st_d = btpc_pkg::S_P_AAP3;
			btpc_pkg::S_P_AAP3: if (mdone) st_d = btpc_pkg::S_P_AP2;
			btpc_pkg::S_P_AP2:  if (mdone) st_d = btpc_pkg::S_P_P1;
			btpc_pkg::S_P_P1:   if (mdone) st_d = btpc_pkg::S_P_CHK;
			btpc_pkg::S_P_CHK:  st_d = (ra_q == 64'd0) ? btpc_pkg::S_OUT : btpc_pkg::S_P_N;
			btpc_pkg::S_P_N:    if (mdone) st_d = btpc_pkg::S_P_DIV;
			btpc_pkg::S_P_DIV:  st_d = btpc_pkg::S_P_WAIT;
			btpc_pkg::S_P_WAIT: if (ddone) st_d = btpc_pkg::S_P_PS2;
			btpc_pkg::S_P_PS2:  if (mdone) st_d = btpc_pkg::S_P_P9;
			btpc_pkg::S_P_P9:   if (mdone) st_d = btpc_pkg::S_P_P8;
			btpc_pkg::S_P_P8:   if (mdone) st_d = btpc_pkg::S_P_FIN;
			btpc_pkg::S_P_FIN:  st_d = btpc_pkg::S_OUT;
			btpc_pkg::S_OUT:    st_d = btpc_pkg::S_IDLE;
			default:            st_d = btpc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= btpc_pkg::S_IDLE;
			launched_q <= 1'b0;
			m_tvalid   <= 1'b0;
			tfine_q    <= 32'd0;
		end else begin
			st_q <= st_d;
			if (mstart) launched_q <= 1'b1;
			else if (mdone) launched_q <= 1'b0;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (st_q == btpc_pkg::S_OUT) m_tvalid <= 1'b1;
			if (st_q == btpc_pkg::S_T_OUT) tfine_q <= rb_q[31:0];
		end
	end

	// p = 2^20 - adc fits 21 bits; (p << 31) - b
	logic [20:0] p_raw;
	logic [63:0] pre_div, p_sum;
	logic [31:0] t_round;
	always_comb begin
		p_raw = 21'd1048576 - {1'b0, adc_q};
		pre_div = {12'd0, p_raw, 31'd0} - rc_q;
		p_sum = rd_q + rb_q + {{19{mp[63]}}, mp[63:19]};
		// temperature rounding: (tfine*5 + 128) >>> 8
		t_round = mp[31:0] + 32'd128;
	end

	// datapath scratch: ra/rb/rc/rd meaning depends on phase
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			adc_q  <= s_tdata[19:0];
			kind_q <= s_tuser;
			dz_q   <= 1'b0;
			temp_out_q  <= 32'd0;
			press_out_q <= 32'd0;
			ra_q <= {{32{tfine_q[31]}}, tfine_q} - 64'd128000;
		end
		if (mdone) begin
			unique case (st_q)
				btpc_pkg::S_T_A:    rb_q <= {32'd0, {{11{mp[31]}}, mp[31:11]}};
				btpc_pkg::S_T_DD:   ra_q <= {32'd0, mp[31:0]};
				btpc_pkg::S_T_B:    rb_q <= {32'd0, rb_q[31:0] + {{14{mp[31]}}, mp[31:14]}};
				btpc_pkg::S_T_FIN:  temp_out_q <= {{8{t_round[31]}}, t_round[31:8]};
				btpc_pkg::S_P_AA:   rb_q <= mp;
				btpc_pkg::S_P_AAP6: rc_q <= mp + {p4[28:0], 35'd0};
				btpc_pkg::S_P_AP5:  rc_q <= rc_q + {mp[46:0], 17'd0};
				btpc_pkg::S_P_AAP3: rd_q <= {{8{mp[63]}}, mp[63:8]};
				btpc_pkg::S_P_AP2:  rd_q <= rd_q + {mp[51:0], 12'd0} + 64'h0000_8000_0000_0000;
				btpc_pkg::S_P_P1:   ra_q <= {{33{mp[63]}}, mp[63:33]};
				btpc_pkg::S_P_N:    rd_q <= mp;
				btpc_pkg::S_P_PS2:  rb_q <= mp;
				btpc_pkg::S_P_P9:   rb_q <= {{25{mp[63]}}, mp[63:25]};
				btpc_pkg::S_P_P8:   rc_q <= p_sum;
				default: ;
			endcase
		end
		if (st_q == btpc_pkg::S_P_CHK) begin
			if (ra_q == 64'd0) dz_q <= 1'b1;
			else rd_q <= pre_div;
		end
		if (ddone) begin
			ra_q <= dq;
			rd_q <= dq;
		end
		if (st_q == btpc_pkg::S_P_FIN) begin
			press_out_q <= rc_q[39:8] + {p7[27:0], 4'd0};
		end
		if (st_q == btpc_pkg::S_OUT) begin
			m_tuser <= kind_q;
			m_tdata <= {7'd0, dz_q, press_out_q, temp_out_q};
		end
	end
endmodule

[design/btpc_mul.sv]
// 64x64 -> low 64 product, built from three 32x32 partial products in turn.
module btpc_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [btpc_pkg::DataW-1:0]      a,
	input  logic [btpc_pkg::DataW-1:0]      b,
	output logic                            done,
	output logic [btpc_pkg::DataW-1:0]      p
);
	logic [1:0]  step_q;
	logic        busy_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [31:0] x, y;
	logic [63:0] pp;

	always_comb begin
		x = step_q[0] ? a_q[63:32] : a_q[31:0];
		y = step_q[1] ? b_q[63:32] : b_q[31:0];
		pp = {32'd0, x} * {32'd0, y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= 64'd0;
		end else if (busy_q) begin
			unique case (step_q)
				2'd0:    acc_q <= acc_q + pp;
				2'd1:    acc_q <= acc_q + {pp[31:0], 32'd0};
				2'd2:    acc_q <= acc_q + {pp[31:0], 32'd0};
				default: acc_q <= acc_q;
			endcase
		end
	end

	// step 3 never used; high*high vanishes mod 2^64
	assign p = acc_q;
endmodule

[design/btpc_div.sv]
// Signed 64-bit divide, truncating toward zero, one quotient bit per cycle.
module btpc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  btpc_pkg::div_ctl_t         ctl_in,
	input  logic [btpc_pkg::DataW-1:0] dividend,
	input  logic [btpc_pkg::DataW-1:0] divisor,
	output logic                       done,
	output logic [btpc_pkg::DataW-1:0] quotient
);
	logic [6:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [63:0] q_q, r_q, d_q;
	logic [64:0] trial;
	logic [63:0] rsh;

	always_comb begin
		rsh   = {r_q[62:0], q_q[63]};
		trial = {1'b0, rsh} - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 7'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			q_q   <= dividend[63] ? (64'd0 - dividend) : dividend;
			d_q   <= divisor[63] ? (64'd0 - divisor) : divisor;
			r_q   <= 64'd0;
			neg_q <= dividend[63] ^ divisor[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= rsh;
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? (64'd0 - q_q) : q_q;
endmodule

[design/btpc_checker.sv]
module btpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");
	a_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[64] == 1'b0 && m_tdata[63:32] == 32'd0)
		else $error("temperature beat with pressure bits");
	a_press_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("pressure beat with temperature bits");
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a second beat while busy");
endmodule

bind baro_temp_pressure_compensation_top btpc_checker u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .s_tuser, .m_tvalid, .m_tready, .m_tdata, .m_tuser);
